// ===== sv/whole_word_masking_filter_macros.svh =====
// assertion macros shared by the whole_word_masking_filter checkers
// expects clk and rst in the scope where a macro is used
`ifndef WHOLE_WORD_MASKING_FILTER_MACROS_SVH
`define WHOLE_WORD_MASKING_FILTER_MACROS_SVH

// same-cycle implication, disabled in reset
`define WWMF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define WWMF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/wwmf_pkg.sv =====
// shared types, constants and helpers of the whole-word masking filter
// no dependencies
package wwmf_pkg;

  localparam int NUM_WORDS_DEF = 16;
  localparam int MAX_LEN_DEF   = 32;

  localparam int S_DATA_W = 24;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 8;
  localparam int M_USER_W = 1;

  localparam logic [7:0] MASK_CHAR  = 8'h2A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_PERIOD  = 8'h2E;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_NUL     = 8'h00;

  typedef enum logic [1:0] {
    ACT_DICT_CHAR = 2'd0,
    ACT_WORD_LEN  = 2'd1,
    ACT_TEXT      = 2'd2,
    ACT_NONE      = 2'd3
  } action_t;

  typedef struct packed {
    logic latch_item;
    logic dict_wr;
    logic len_wr;
    logic char_step;
    logic start_cmp;
    logic cmp_chk;
    logic start_emit;
    logic set_pt;
    logic clr_pt;
    logic load_buf_out;
    logic next_idx;
    logic load_tail;
  } dp_cmd_t;

  typedef struct packed {
    action_t action;
    logic    is_delim;
    logic    passthrough;
    logic    full;
    logic    count_zero;
    logic    idx_last;
  } dp_status_t;

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_COMMA) || (c == CH_PERIOD) ||
           (c == CH_NEWLINE) || (c == CH_NUL);
  endfunction

endpackage

// ===== sv/whole_word_masking_filter.sv =====
// whole-word masking filter, top level: controller plus datapath
// dictionary requests finish in idle; a token-extending text character passes decide
// a delimiter passes decide, then read and check per buffered character, match, and
// emit load and wait per result; flush, passthrough and empty tokens skip the compare
// synchronous reset clears slot lengths, token count and passthrough; no clearing pass
// depends on wwmf_pkg, wwmf_ctrl, wwmf_dpath
module whole_word_masking_filter #(
  parameter int NUM_WORDS = wwmf_pkg::NUM_WORDS_DEF,
  parameter int MAX_LEN   = wwmf_pkg::MAX_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // word_slot[3:0], char_pos[8:4], char_value[16:9], word_length[22:17]
  input  logic [wwmf_pkg::S_DATA_W-1:0] s_tdata,
  // action[1:0]
  input  logic [wwmf_pkg::S_USER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // char_out[7:0]
  output logic [wwmf_pkg::M_DATA_W-1:0] m_tdata,
  // was_masked[0]
  output logic [wwmf_pkg::M_USER_W-1:0] m_tuser,
  // last_of_run
  output logic                          m_tlast
);
  import wwmf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  wwmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  wwmf_dpath #(
    .NUM_WORDS (NUM_WORDS),
    .MAX_LEN   (MAX_LEN)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .cmd     (cmd),
    .status  (status),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

// ===== sv/wwmf_ctrl.sv =====
// controller of the whole-word masking filter: sequences each request
// depends on wwmf_pkg
module wwmf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  wwmf_pkg::dp_status_t status,
  output wwmf_pkg::dp_cmd_t    cmd
);
  import wwmf_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_DECIDE    = 9'b000000010,
    ST_CMP_RD    = 9'b000000100,
    ST_CMP_CHK   = 9'b000001000,
    ST_MATCH     = 9'b000010000,
    ST_EMIT_LOAD = 9'b000100000,
    ST_EMIT_WAIT = 9'b001000000,
    ST_TAIL_LOAD = 9'b010000000,
    ST_TAIL_WAIT = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_EMIT_WAIT) || (state == ST_TAIL_WAIT);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.latch_item = 1'b1;
          unique case (status.action)
            ACT_DICT_CHAR: cmd.dict_wr = 1'b1;
            ACT_WORD_LEN:  cmd.len_wr = 1'b1;
            ACT_TEXT:      state_next = ST_DECIDE;
            ACT_NONE:      state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
          endcase
        end
      end
      ST_DECIDE: begin
        priority if (status.is_delim && status.passthrough) begin
          cmd.clr_pt = 1'b1;
          state_next = ST_TAIL_LOAD;
        end else if (status.is_delim && status.count_zero) begin
          state_next = ST_TAIL_LOAD;
        end else if (status.is_delim) begin
          cmd.start_cmp = 1'b1;
          state_next    = ST_CMP_RD;
        end else if (status.passthrough) begin
          state_next = ST_TAIL_LOAD;
        end else if (!status.full) begin
          cmd.char_step = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          // token too long: flush it unmasked and pass the rest through
          cmd.start_emit = 1'b1;
          cmd.set_pt     = 1'b1;
          state_next     = ST_EMIT_LOAD;
        end
      end
      ST_CMP_RD: begin
        state_next = ST_CMP_CHK;
      end
      ST_CMP_CHK: begin
        cmd.cmp_chk = 1'b1;
        if (status.idx_last) begin
          state_next = ST_MATCH;
        end else begin
          cmd.next_idx = 1'b1;
          state_next   = ST_CMP_RD;
        end
      end
      ST_MATCH: begin
        cmd.start_emit = 1'b1;
        state_next     = ST_EMIT_LOAD;
      end
      ST_EMIT_LOAD: begin
        cmd.load_buf_out = 1'b1;
        state_next       = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (m_tready) begin
          if (status.idx_last) begin
            state_next = ST_TAIL_LOAD;
          end else begin
            cmd.next_idx = 1'b1;
            state_next   = ST_EMIT_LOAD;
          end
        end
      end
      ST_TAIL_LOAD: begin
        cmd.load_tail = 1'b1;
        state_next    = ST_TAIL_WAIT;
      end
      ST_TAIL_WAIT: begin
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/wwmf_dpath.sv =====
// datapath of the whole-word masking filter: dictionary lanes, token buffer,
// match flags and output register; depends on wwmf_pkg
module wwmf_dpath #(
  parameter int NUM_WORDS = wwmf_pkg::NUM_WORDS_DEF,
  parameter int MAX_LEN   = wwmf_pkg::MAX_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [wwmf_pkg::S_DATA_W-1:0] s_tdata,
  input  logic [wwmf_pkg::S_USER_W-1:0] s_tuser,
  input  wwmf_pkg::dp_cmd_t             cmd,
  output wwmf_pkg::dp_status_t          status,
  output logic [wwmf_pkg::M_DATA_W-1:0] m_tdata,
  output logic [wwmf_pkg::M_USER_W-1:0] m_tuser,
  output logic                          m_tlast
);
  import wwmf_pkg::*;

  localparam int IW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW    = $clog2(MAX_LEN + 1);
  localparam int DEPTH = 1 << IW;

  logic [3:0] in_slot;
  logic [4:0] in_pos;
  logic [7:0] in_char;
  logic [5:0] in_len;
  logic       pos_ok;
  logic [CW-1:0] sat_len;

  assign in_slot = s_tdata[3:0];
  assign in_pos  = s_tdata[8:4];
  assign in_char = s_tdata[16:9];
  assign in_len  = s_tdata[22:17];
  assign pos_ok  = (32'(in_pos) < MAX_LEN);
  assign sat_len = (in_len > 6'(MAX_LEN)) ? CW'(MAX_LEN) : CW'(in_len);

  logic [7:0]    item_char;
  logic [CW-1:0] count;
  logic [IW-1:0] idx;
  logic          pt;
  logic          hit;
  logic [NUM_WORDS-1:0] flags;
  logic [NUM_WORDS-1:0] len_hit;
  logic [7:0]    lane_rd [NUM_WORDS];
  logic [CW-1:0] dlen    [NUM_WORDS];
  logic [7:0]    tok_buf [DEPTH];
  logic          match_any;

  // one dictionary lane per slot, all read at the compare index
  for (genvar s = 0; s < NUM_WORDS; s++) begin : g_lane
    logic [7:0] lane_mem [DEPTH];

    always_ff @(posedge clk) begin
      if (cmd.dict_wr && pos_ok && (32'(in_slot) == s)) begin
        lane_mem[IW'(in_pos)] <= in_char;
      end
      lane_rd[s] <= lane_mem[idx];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dlen[s] <= '0;
      end else if (cmd.len_wr && (32'(in_slot) == s)) begin
        dlen[s] <= sat_len;
      end
    end

    assign len_hit[s] = (dlen[s] == count);
  end

  assign match_any = |(flags & len_hit);

  // per-slot match, walked over the buffered token against the current dictionary
  always_ff @(posedge clk) begin
    if (cmd.start_cmp) begin
      flags <= '1;
    end else if (cmd.cmp_chk) begin
      for (int s = 0; s < NUM_WORDS; s++) begin
        flags[s] <= flags[s] && (lane_rd[s] == tok_buf[idx]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item_char <= in_char;
    end
    if (cmd.char_step) begin
      tok_buf[count[IW-1:0]] <= item_char;
    end
    if (cmd.start_emit) begin
      hit <= is_delim(item_char) && match_any;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pt    <= 1'b0;
      idx   <= '0;
    end else begin
      if (cmd.char_step) begin
        count <= count + CW'(1);
      end else if (cmd.load_tail) begin
        count <= '0;
      end
      if (cmd.set_pt) begin
        pt <= 1'b1;
      end else if (cmd.clr_pt) begin
        pt <= 1'b0;
      end
      if (cmd.start_emit || cmd.start_cmp) begin
        idx <= '0;
      end else if (cmd.next_idx) begin
        idx <= idx + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_buf_out) begin
      m_tdata <= hit ? MASK_CHAR : tok_buf[idx];
      m_tuser <= M_USER_W'(hit);
      m_tlast <= 1'b0;
    end else if (cmd.load_tail) begin
      m_tdata <= item_char;
      m_tuser <= '0;
      m_tlast <= 1'b1;
    end
  end

  assign status.action      = action_t'(s_tuser);
  assign status.is_delim    = is_delim(item_char);
  assign status.passthrough = pt;
  assign status.full        = (count == CW'(MAX_LEN));
  assign status.count_zero  = (count == '0);
  assign status.idx_last    = ((CW'(idx) + CW'(1)) == count);

endmodule

// ===== sv/wwmf_checker.sv =====
// port-level checks of the whole-word masking filter, bound to the top level
// depends on wwmf_pkg and whole_word_masking_filter_macros.svh
`include "whole_word_masking_filter_macros.svh"

module wwmf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [wwmf_pkg::M_DATA_W-1:0] m_tdata,
  input logic [wwmf_pkg::M_USER_W-1:0] m_tuser,
  input logic                          m_tlast
);
  import wwmf_pkg::*;

  // one request at a time: no intake while a result is shown
  `WWMF_ASSERT_IMP(a_no_overlap, s_tready, !m_tvalid, "ready while a result is pending")

  `WWMF_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
    "stalled result changed")

  `WWMF_ASSERT_IMP(a_mask_char, m_tvalid && m_tuser[0], m_tdata == MASK_CHAR,
    "masked result is not an asterisk")

  // the final result is always the delimiter or passthrough byte, never masked
  `WWMF_ASSERT_IMP(a_last_unmasked, m_tvalid && m_tlast, !m_tuser[0],
    "last result marked masked")

  `WWMF_ASSERT_NXT(a_ready_after_last, m_tvalid && m_tready && m_tlast, s_tready,
    "not ready after the last result")

endmodule

bind whole_word_masking_filter wwmf_checker u_wwmf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== dv/whole_word_masking_filter_tb.sv =====
// testbench for whole_word_masking_filter: directed table, then random dictionary
// loads and text phrases checked against an in-bench censor model
// depends on wwmf_pkg and the whole_word_masking_filter rtl
module whole_word_masking_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wwmf_pkg::*;

  localparam int NSLOT        = NUM_WORDS_DEF;
  localparam int WORD_MAX     = MAX_LEN_DEF;
  localparam int RAND_ITEMS   = 135;
  localparam int LIMIT_CYCLES = 400000;

  typedef enum logic [1:0] {
    BY_MODEL   = 2'd0,
    NO_RESULT  = 2'd1,
    ONE_RESULT = 2'd2
  } row_check_t;

  typedef struct packed {
    action_t    act;
    logic [3:0] slot;
    logic [4:0] pos;
    logic [7:0] ch;
    logic [5:0] len;
    row_check_t chk;
    logic [7:0] exp_ch;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       masked;
    logic       last;
  } out_rec_t;

  // one-result rows are always a lone delimiter, so was_masked=0 and last=1
  localparam int DIR_N = 20;
  localparam dir_row_t DIRECTED [DIR_N] = '{
    '{ACT_TEXT,      4'd0,  5'd0,  CH_SPACE,   6'd0,  ONE_RESULT, CH_SPACE},
    '{ACT_DICT_CHAR, 4'd0,  5'd0,  8'h61,      6'd0,  NO_RESULT,  8'h00},
    '{ACT_DICT_CHAR, 4'd0,  5'd1,  8'h62,      6'd0,  NO_RESULT,  8'h00},
    '{ACT_WORD_LEN,  4'd0,  5'd0,  8'h00,      6'd2,  NO_RESULT,  8'h00},
    '{ACT_TEXT,      4'd0,  5'd0,  8'h61,      6'd0,  BY_MODEL,   8'h00},
    '{ACT_TEXT,      4'd0,  5'd0,  8'h62,      6'd0,  BY_MODEL,   8'h00},
    '{ACT_TEXT,      4'd0,  5'd0,  CH_COMMA,   6'd0,  BY_MODEL,   8'h00},
    '{ACT_TEXT,      4'd0,  5'd0,  8'h61,      6'd0,  BY_MODEL,   8'h00},
    '{ACT_TEXT,      4'd0,  5'd0,  8'h62,      6'd0,  BY_MODEL,   8'h00},
    '{ACT_TEXT,      4'd0,  5'd0,  8'hFF,      6'd0,  BY_MODEL,   8'h00},
    '{ACT_TEXT,      4'd0,  5'd0,  CH_PERIOD,  6'd0,  BY_MODEL,   8'h00},
    '{ACT_TEXT,      4'd0,  5'd0,  CH_NEWLINE, 6'd0,  ONE_RESULT, CH_NEWLINE},
    '{ACT_TEXT,      4'd0,  5'd0,  8'h62,      6'd0,  BY_MODEL,   8'h00},
    '{ACT_TEXT,      4'd0,  5'd0,  CH_NUL,     6'd0,  BY_MODEL,   8'h00},
    '{ACT_NONE,      4'd15, 5'd31, 8'hFF,      6'd63, NO_RESULT,  8'h00},
    '{ACT_DICT_CHAR, 4'd15, 5'd31, 8'hFF,      6'd63, NO_RESULT,  8'h00},
    '{ACT_WORD_LEN,  4'd0,  5'd0,  8'h00,      6'd0,  NO_RESULT,  8'h00},
    '{ACT_TEXT,      4'd0,  5'd0,  8'h61,      6'd0,  BY_MODEL,   8'h00},
    '{ACT_TEXT,      4'd0,  5'd0,  8'h62,      6'd0,  BY_MODEL,   8'h00},
    '{ACT_TEXT,      4'd0,  5'd0,  CH_SPACE,   6'd0,  BY_MODEL,   8'h00}
  };

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic [S_USER_W-1:0] s_tuser  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [M_USER_W-1:0] m_tuser;
  logic                m_tlast;

  // censor model state
  logic [7:0] dict_bytes   [NSLOT][WORD_MAX];
  bit         dict_written [NSLOT][WORD_MAX];
  int         dict_len     [NSLOT];
  logic [7:0] tok_buf      [WORD_MAX];
  int         tok_cnt   = 0;
  bit         pass_mode = 1'b0;

  out_rec_t pending_chars[$];
  out_rec_t want;
  int       n_fail     = 0;
  int       n_sent     = 0;
  int       burst_left = 0;
  int       cycles     = 0;
  int       ready_pct  = 100;
  int       phase_left = 0;

  whole_word_masking_filter uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: stall phases of random length and density
  always @(posedge clk) begin
    if (phase_left == 0) begin
      phase_left = $urandom_range(20, 120);
      case ($urandom_range(0, 3))
        0: ready_pct = 100;
        1: ready_pct = 75;
        2: ready_pct = 40;
        default: ready_pct = 10;
      endcase
    end
    phase_left--;
    m_tready <= ($urandom_range(1, 100) <= ready_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_chars.size() == 0) begin
        $error("result with none pending: char_out=%0h", m_tdata);
        n_fail++;
      end else begin
        want = pending_chars.pop_front();
        if (m_tdata !== want.ch) begin
          $error("char_out: expected %0h, got %0h", want.ch, m_tdata);
          n_fail++;
        end
        if (m_tuser[0] !== want.masked) begin
          $error("was_masked: expected %0b, got %0b", want.masked, m_tuser[0]);
          n_fail++;
        end
        if (m_tlast !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, m_tlast);
          n_fail++;
        end
      end
    end
  end

  function automatic bit is_sep(input logic [7:0] c);
    return c inside {CH_SPACE, CH_COMMA, CH_PERIOD, CH_NEWLINE, CH_NUL};
  endfunction

  function automatic bit token_hits_word();
    bit same;
    if (tok_cnt == 0) return 1'b0;
    for (int s = 0; s < NSLOT; s++) begin
      if (dict_len[s] != tok_cnt) continue;
      same = 1'b1;
      for (int k = 0; k < tok_cnt; k++)
        if (dict_bytes[s][k] != tok_buf[k]) same = 1'b0;
      if (same) return 1'b1;
    end
    return 1'b0;
  endfunction

  // works out the bytes one request releases; state is always updated,
  // the results are queued only when keep is set
  task automatic censor_step(input action_t act, input logic [3:0] slot,
                             input logic [4:0] pos, input logic [7:0] ch,
                             input logic [5:0] len, input bit keep);
    out_rec_t burst[$];
    bit       hit;
    case (act)
      ACT_DICT_CHAR: begin
        dict_bytes[slot][pos]   = ch;
        dict_written[slot][pos] = 1'b1;
      end
      ACT_WORD_LEN: dict_len[slot] = (len > WORD_MAX) ? WORD_MAX : int'(len);
      ACT_TEXT: begin
        if (is_sep(ch)) begin
          if (pass_mode) begin
            pass_mode = 1'b0;
          end else begin
            hit = token_hits_word();
            for (int k = 0; k < tok_cnt; k++)
              burst.push_back('{hit ? MASK_CHAR : tok_buf[k], hit, 1'b0});
          end
          tok_cnt = 0;
          burst.push_back('{ch, 1'b0, 1'b0});
        end else if (pass_mode) begin
          burst.push_back('{ch, 1'b0, 1'b0});
        end else if (tok_cnt < WORD_MAX) begin
          tok_buf[tok_cnt] = ch;
          tok_cnt++;
        end else begin
          // overlong token: flush as is and pass the rest through
          for (int k = 0; k < tok_cnt; k++)
            burst.push_back('{tok_buf[k], 1'b0, 1'b0});
          burst.push_back('{ch, 1'b0, 1'b0});
          tok_cnt   = 0;
          pass_mode = 1'b1;
        end
      end
      default: ;
    endcase
    if (burst.size() != 0) burst[burst.size()-1].last = 1'b1;
    if (keep)
      foreach (burst[k]) pending_chars.push_back(burst[k]);
  endtask

  // drives one request in bursts with random gaps, returns after acceptance
  task automatic send_req(input action_t act, input logic [3:0] slot,
                          input logic [4:0] pos, input logic [7:0] ch,
                          input logic [5:0] len, input row_check_t chk,
                          input logic [7:0] exp_ch);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, len, ch, pos, slot};
    s_tuser  <= act;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (chk == ONE_RESULT) pending_chars.push_back('{exp_ch, 1'b0, 1'b1});
    censor_step(act, slot, pos, ch, len, chk == BY_MODEL);
    if (act != ACT_NONE) n_sent++;
  endtask

  task automatic send_text(input logic [7:0] ch);
    send_req(ACT_TEXT, 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)), ch,
             6'($urandom_range(0, 63)), BY_MODEL, 8'h00);
  endtask

  task automatic send_dict(input int slot, input int pos, input logic [7:0] ch);
    send_req(ACT_DICT_CHAR, 4'(slot), 5'(pos), ch, 6'($urandom_range(0, 63)),
             BY_MODEL, 8'h00);
  endtask

  task automatic send_len(input int slot, input int len);
    send_req(ACT_WORD_LEN, 4'(slot), 5'($urandom_range(0, 31)),
             8'($urandom_range(0, 255)), 6'(len), BY_MODEL, 8'h00);
  endtask

  // mostly a small alphabet so that near misses against words are common
  function automatic logic [7:0] word_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) return 8'(8'h61 + $urandom_range(0, 3));
    do c = 8'($urandom_range(0, 255)); while (is_sep(c));
    return c;
  endfunction

  function automatic logic [7:0] sep_char();
    case ($urandom_range(0, 4))
      0: return CH_SPACE;
      1: return CH_COMMA;
      2: return CH_PERIOD;
      3: return CH_NEWLINE;
      default: return CH_NUL;
    endcase
  endfunction

  function automatic int written_prefix(input int slot);
    int n;
    n = 0;
    while (n < WORD_MAX && dict_written[slot][n]) n++;
    return n;
  endfunction

  // every byte inside the new length is written before the length itself
  task automatic load_word();
    int slot, want_len, n;
    slot = $urandom_range(0, 15);
    case ($urandom_range(0, 9))
      0: want_len = 0;
      1: want_len = $urandom_range(32, 63);
      default: want_len = $urandom_range(1, 5);
    endcase
    n = (want_len > WORD_MAX) ? WORD_MAX : want_len;
    for (int k = 0; k < n; k++)
      send_dict(slot, k, ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                      : word_char());
    send_len(slot, want_len);
  endtask

  task automatic say_phrase();
    logic [7:0] tok[$];
    int         slot, mode, n, k;
    repeat ($urandom_range(1, 4)) begin
      tok.delete();
      slot = -1;
      repeat (8) begin
        k = $urandom_range(0, 15);
        if (dict_len[k] != 0) slot = k;
      end
      mode = $urandom_range(0, 9);
      if (slot >= 0 && mode < 6) begin
        for (int j = 0; j < dict_len[slot]; j++) tok.push_back(dict_bytes[slot][j]);
        case (mode)
          3: tok.push_back(word_char());
          4: void'(tok.pop_back());
          5: tok[$urandom_range(0, tok.size() - 1)] = word_char();
          default: ;
        endcase
      end else begin
        n = (mode == 9) ? $urandom_range(30, 40) : $urandom_range(0, 4);
        repeat (n) tok.push_back(word_char());
      end
      foreach (tok[j]) send_text(tok[j]);
      send_text(sep_char());
    end
  endtask

  task automatic noise_item();
    int slot, want_len;
    slot = $urandom_range(0, 15);
    case ($urandom_range(0, 3))
      0: send_req(ACT_NONE, 4'(slot), 5'($urandom_range(0, 31)),
                  8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                  BY_MODEL, 8'h00);
      1: send_text(8'($urandom_range(0, 255)));
      2: send_dict(slot, $urandom_range(0, 31), 8'($urandom_range(0, 255)));
      default: begin
        want_len = $urandom_range(0, 63);
        if (written_prefix(slot) < ((want_len > WORD_MAX) ? WORD_MAX : want_len))
          want_len = 0;
        send_len(slot, want_len);
      end
    endcase
  endtask

  initial begin
    bit drained;
    drained = 1'b0;
    foreach (dict_len[s]) dict_len[s] = 0;
    foreach (dict_written[s, k]) dict_written[s][k] = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i])
      send_req(DIRECTED[i].act, DIRECTED[i].slot, DIRECTED[i].pos, DIRECTED[i].ch,
               DIRECTED[i].len, DIRECTED[i].chk, DIRECTED[i].exp_ch);

    while (n_sent < DIR_N + RAND_ITEMS) begin
      if (!drained && n_sent >= DIR_N + RAND_ITEMS / 2) begin
        // hold the sender until every pending byte has come out
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_chars.size() != 0);
        burst_left = 0;
        drained    = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: load_word();
        9: noise_item();
        default: say_phrase();
      endcase
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0);
    repeat (60) @(posedge clk);
    if (n_fail == 0 && pending_chars.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
